// ===== hw/rtl/tkdlp_pkg.sv =====
// Shared types and constants for the three-key debounce and long-press block.
package tkdlp_pkg;

    localparam int KEY_COUNT = 3;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CODE_W    = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd3000;

    typedef enum logic [0:0] {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } cfg_index_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE     = 3'd0,
        EV_K0_SHORT = 3'd1,
        EV_K0_LONG  = 3'd2,
        EV_K1_SHORT = 3'd3,
        EV_K2_SHORT = 3'd4
    } event_code_t;

    // What one lane found for the current word.
    typedef struct packed {
        logic release_held;
        logic is_long;
    } lane_status_t;

endpackage

// ===== hw/rtl/tkdlp_lane.sv =====
// One key lane: debounce state, press timing and release detection.
module tkdlp_lane
    import tkdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  logic              level,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [CFG_W-1:0]  debounce_ms,
    input  logic [CFG_W-1:0]  long_press_ms,
    output lane_status_t      status
);

    logic              stable_reg, stable_next;
    logic              held_reg, held_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic              take;

    assign since_change = now_ms - change_time_reg;
    assign since_press  = now_ms - press_time_reg;
    assign take = (level != stable_reg) && (since_change >= {16'd0, debounce_ms});

    assign status.release_held = take && !level && held_reg;
    assign status.is_long      = since_press >= {16'd0, long_press_ms};

    always_comb
    begin
        stable_next      = stable_reg;
        held_next        = held_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        if (level == stable_reg)
        begin
            change_time_next = now_ms;
        end
        else if (take)
        begin
            stable_next      = level;
            change_time_next = now_ms;
            if (level)
            begin
                held_next       = 1'b1;
                press_time_next = now_ms;
            end
            else
            begin
                held_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b0;
            held_reg        <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
        end
        else if (commit)
        begin
            stable_reg      <= stable_next;
            held_reg        <= held_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

endmodule

// ===== hw/rtl/tkdlp_merge.sv =====
// Merge of lane findings: first release wins, later lanes hold their state.
module tkdlp_merge
    import tkdlp_pkg::*;
(
    input  logic                         accept,
    input  lane_status_t [KEY_COUNT-1:0] lane_status,
    output logic [KEY_COUNT-1:0]         commit,
    output event_code_t                  code
);

    always_comb
    begin
        commit[0] = accept;
        commit[1] = accept && !lane_status[0].release_held;
        commit[2] = commit[1] && !lane_status[1].release_held;
    end

    always_comb
    begin
        priority if (lane_status[0].release_held)
            code = lane_status[0].is_long ? EV_K0_LONG : EV_K0_SHORT;
        else if (lane_status[1].release_held)
            code = lane_status[1].is_long ? EV_NONE : EV_K1_SHORT;
        else if (lane_status[2].release_held)
            code = lane_status[2].is_long ? EV_NONE : EV_K2_SHORT;
        else
            code = EV_NONE;
    end

endmodule

// ===== hw/rtl/tkdlp_out_buf.sv =====
// Output register with a skid stage for result words.
module tkdlp_out_buf
    import tkdlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  event_code_t in_code,
    output logic        in_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [2:0] event_code, [7:3] zero
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    event_code_t out_code_reg, out_code_next;
    event_code_t skid_code_reg, skid_code_next;
    logic        drain;

    assign in_ready = !skid_valid_reg;
    assign drain    = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_code_reg};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_code_next   = out_code_reg;
        skid_code_next  = skid_code_reg;
        if (!out_valid_reg || drain)
        begin
            // Refill the output from the skid first, then from the new word.
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = skid_code_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_code_next  = in_code;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_code_next  = in_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        skid_code_reg <= skid_code_next;
    end

endmodule

// ===== hw/rtl/three_key_debounce_long_press.sv =====
// Top level of the three-key debouncer with long-press detection.
//
// Each input word carries three key levels (1 = pressed) and a 32-bit
// millisecond time stamp; each word yields exactly one result word holding an
// event code: 0 none, 1 key 0 short, 2 key 0 long, 3 key 1 short, 4 key 2
// short. A key's level must differ from its stable level for debounce_ms
// before it is taken; a release of a held key reports short or long against
// long_press_ms (a long release of key 1 or 2 reports nothing) and stops the
// scan, so higher keys keep their state for that word. Elapsed times wrap
// modulo 2^32. The block takes one word per clock while s_tready is high;
// three key lanes evaluate in parallel in the accept cycle, a priority merge
// picks the first release and gates the state update of later lanes, and the
// event code is registered in the output register, or in the skid stage when
// that is full, keeping input accepted while a result waits; s_tready drops only
// when both are full. Configuration registers (index 0 debounce_ms, reset 30;
// index 1 long_press_ms, reset 3000) are written with cfg_we; the user must
// write them only while no word is in flight; the block does not enforce it.
module three_key_debounce_long_press
    import tkdlp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // [2:0] key_levels, [34:3] now_ms, [39:35] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [2:0] event_code, [7:3] zero
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] long_press_reg;

    logic [KEY_COUNT-1:0]         key_levels;
    logic [TIME_W-1:0]            now_ms;
    logic                         accept;
    logic [KEY_COUNT-1:0]         commit;
    lane_status_t [KEY_COUNT-1:0] lane_status;
    event_code_t                  code;

    assign key_levels = s_tdata[KEY_COUNT-1:0];
    assign now_ms     = s_tdata[KEY_COUNT +: TIME_W];
    assign accept     = s_tvalid && s_tready;

    // Hold configuration; the user must write only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // One lane per key, all evaluated against the same word.
    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_lane
        tkdlp_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .commit        (commit[k]),
            .level         (key_levels[k]),
            .now_ms        (now_ms),
            .debounce_ms   (debounce_reg),
            .long_press_ms (long_press_reg),
            .status        (lane_status[k])
        );
    end

    // Pick the first release and drop state updates of the keys after it.
    tkdlp_merge u_merge (
        .accept      (accept),
        .lane_status (lane_status),
        .commit      (commit),
        .code        (code)
    );

    tkdlp_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_code  (code),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
